@@ rtl/kmd_pkg.sv @@
package kmd_pkg;

    // Time stamps run modulo this value; a stamp of 8'hFF counts as zero when
    // the elapsed time is worked out
    localparam int unsigned TIME_MODULUS = 255;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

    typedef struct packed {
        logic [3:0] key_col;
        logic [2:0] key_row;
        logic       level;
        logic [7:0] now_ms;
        logic       sink_accepts;
    } in_word_t;

    typedef struct packed {
        logic [3:0] event_col;
        logic [2:0] event_row;
        logic       event_pressed;
    } out_word_t;

    // One entry of the key state memory
    typedef struct packed {
        logic       stable_level;
        logic [7:0] agree_time;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Outcome of evaluating one word against its key entry
    typedef struct packed {
        logic   emit;
        logic   wr_en;
        entry_t wr_data;
    } dec_t;

endpackage

@@ rtl/kmd_ram.sv @@
module kmd_ram #(
    parameter int WIDTH  = 9,
    parameter int DEPTH  = 70,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/kmd_eval.sv @@
module kmd_eval import kmd_pkg::*; #(
    parameter int ADDR_W = 7
) (
    input  in_word_t          word,
    input  logic              in_range,
    input  logic [ADDR_W-1:0] addr,
    input  entry_t            rd_entry,
    input  logic              fwd_valid,
    input  logic [ADDR_W-1:0] fwd_addr,
    input  entry_t            fwd_entry,
    input  logic [7:0]        debounce_ms,
    output dec_t              dec
);

    entry_t     cur;
    logic       agree;
    logic [7:0] now_mod;
    logic [7:0] agree_mod;
    logic [8:0] diff;
    logic [7:0] elapsed;
    logic       emit;

    always_comb
    begin
        // Take the latest write to this key when the memory read missed it
        cur = (fwd_valid && (fwd_addr == addr)) ? fwd_entry : rd_entry;
        agree = (word.level == cur.stable_level);

        now_mod   = (word.now_ms == 8'(TIME_MODULUS)) ? 8'd0 : word.now_ms;
        agree_mod = (cur.agree_time == 8'(TIME_MODULUS)) ? 8'd0 : cur.agree_time;
        diff      = {1'b0, now_mod} - {1'b0, agree_mod};
        elapsed   = diff[8] ? 8'(diff + 9'(TIME_MODULUS)) : diff[7:0];

        emit = in_range && !agree && (elapsed > debounce_ms);

        dec.emit  = emit;
        dec.wr_en = in_range && (agree || (emit && word.sink_accepts));
        if (agree)
        begin
            dec.wr_data.stable_level = cur.stable_level;
            dec.wr_data.agree_time   = word.now_ms;
        end
        else
        begin
            dec.wr_data.stable_level = word.level;
            dec.wr_data.agree_time   = cur.agree_time;
        end
    end

endmodule

@@ rtl/key_matrix_debouncer.sv @@
// Flow: an accepted word is held in the evaluate stage while the RAM reads its entry; any event
// it yields is then registered in the output register, which drives out_word.
// Throughput: one word per cycle, stalled only while a new event meets a full output register.
// State lives in one single-port-write RAM (registered read), one entry per key.
// Reset: rst_n clears control at once; then a clearing pass over all NUM_COLS * NUM_ROWS
// entries zeroes the key memory, during which no word is accepted (config still is).
// The debounce threshold resets to 5.
module key_matrix_debouncer import kmd_pkg::*; #(
    parameter int NUM_COLS = 14,
    parameter int NUM_ROWS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam int KEY_COUNT = NUM_COLS * NUM_ROWS;
    localparam int ADDR_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Configuration
    logic [7:0] debounce_reg;

    // Clearing pass
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Evaluate stage: holds the word whose entry the RAM is presenting
    logic              s1_valid_reg;
    logic              s1_valid_next;
    in_word_t          s1_word_reg;
    logic              s1_in_range_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // Last write into the RAM, kept for forwarding
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    entry_t            fwd_entry_reg;

    // Output register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;

    logic              in_accept;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic              out_free;
    logic              s1_fire;
    dec_t              dec;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t            rd_entry;

    // Key index: column-major, column times row count plus row
    assign in_range = (32'(in_word.key_col) < NUM_COLS) && (32'(in_word.key_row) < NUM_ROWS);
    assign in_addr  = ADDR_W'(32'(in_word.key_col) * NUM_ROWS + 32'(in_word.key_row));

    // Hold the evaluate stage only when it has an event and nowhere to put it
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && (!dec.emit || out_free);
    assign in_ready  = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign in_accept = in_valid && in_ready;

    assign rd_entry = entry_t'(ram_rd_data);

    kmd_eval #(
        .ADDR_W (ADDR_W)
    ) u_eval (
        .word        (s1_word_reg),
        .in_range    (s1_in_range_reg),
        .addr        (s1_addr_reg),
        .rd_entry    (rd_entry),
        .fwd_valid   (fwd_valid_reg),
        .fwd_addr    (fwd_addr_reg),
        .fwd_entry   (fwd_entry_reg),
        .debounce_ms (debounce_reg),
        .dec         (dec)
    );

    // Write port: the clearing pass owns it after reset, the evaluate stage after that
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = s1_fire && dec.wr_en;
            ram_wr_addr = s1_addr_reg;
            ram_wr_data = dec.wr_data;
        end
    end

    kmd_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (KEY_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        // Advance the clearing pass one entry a cycle; drop busy after the last entry
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(KEY_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end

        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire && dec.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_reg <= cfg_wr_data;
            end
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg     <= in_word;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
        end
        if (ram_wr_en)
        begin
            fwd_addr_reg  <= ram_wr_addr;
            fwd_entry_reg <= ram_wr_data;
        end
        if (s1_fire && dec.emit)
        begin
            out_word_reg.event_col     <= s1_word_reg.key_col;
            out_word_reg.event_row     <= s1_word_reg.key_row;
            out_word_reg.event_pressed <= s1_word_reg.level;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // No word enters while the clearing pass owns the memory
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ready && !s1_valid_reg)
        else $error("word taken during clearing pass");

    // The evaluate stage stalls only on an event blocked by a full output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |-> (dec.emit && out_valid_reg && !out_ready))
        else $error("evaluate stage stalled without cause");

    // Every event names a key inside the matrix
    a_event_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((32'(out_word_reg.event_col) < NUM_COLS)
                           && (32'(out_word_reg.event_row) < NUM_ROWS)))
        else $error("event outside the key matrix");

    // A key outside the matrix never touches the memory
    a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_in_range_reg) |-> !dec.wr_en && !dec.emit)
        else $error("out-of-matrix key changed state");

    // An emitted event lands in the output register on the next edge
    a_event_registered: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dec.emit) |=> out_valid_reg)
        else $error("event lost between stages");

endmodule
